@@ rtl/psrt_pkg.sv @@
`default_nettype none

package psrt_pkg;

    localparam int DATA_W      = 32;
    localparam int MODE_W      = 5;
    localparam int REG_NUM_W   = 4;
    localparam int BANK_N      = 5;
    localparam int BANK_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = 3;

    localparam logic [DATA_W-1:0] CPSR_RESET   = 32'h0000_00D3;
    localparam logic [7:0]        SVC_LOW_BYTE = 8'hD3;
    localparam logic [DATA_W-1:0] MASK_LANE    = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] MASK_FLAGS   = 32'hFF00_0000;
    localparam logic [DATA_W-1:0] MASK_T       = 32'hFFFF_FFDF;
    localparam logic [DATA_W-1:0] MASK_USR     = 32'hFFFF_FF00;
    localparam logic [DATA_W-1:0] HIGH_BASE    = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] VEC_SVC      = 32'h0000_0008;
    localparam logic [DATA_W-1:0] LINK_ARM     = 32'd4;
    localparam logic [DATA_W-1:0] LINK_THUMB   = 32'd2;
    localparam logic [4:0]        ROT_MASK     = 5'h1E;

    localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
    localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
    localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
    localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
    localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
    localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;

    localparam logic [BANK_W-1:0] BANK_FIQ  = 3'd0;
    localparam logic [BANK_W-1:0] BANK_IRQ  = 3'd1;
    localparam logic [BANK_W-1:0] BANK_SVC  = 3'd2;
    localparam logic [BANK_W-1:0] BANK_ABT  = 3'd3;
    localparam logic [BANK_W-1:0] BANK_UND  = 3'd4;
    localparam logic [BANK_W-1:0] BANK_NONE = 3'd5;

    localparam logic [ADDR_W-1:0] ADDR_HIGH_VECTORS = 3'd0;

    typedef enum logic [2:0] {
        REQ_MSR_IMM   = 3'd0,
        REQ_MSR_REG   = 3'd1,
        REQ_MRS       = 3'd2,
        REQ_SVC_ARM   = 3'd3,
        REQ_SVC_THUMB = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_MSR  = 2'd1,
        OP_MRS  = 2'd2,
        OP_SVC  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic                 use_spsr;
        logic [DATA_W-1:0]    lane_mask;
        logic [DATA_W-1:0]    value;
        logic [REG_NUM_W-1:0] dest_reg;
        logic [DATA_W-1:0]    link_value;
        logic [DATA_W-1:0]    branch_target;
    } decoded_t;

    typedef struct packed {
        logic [DATA_W-1:0]    psr_value;
        logic [REG_NUM_W-1:0] dest_reg;
        logic                 write_dest;
        logic [DATA_W-1:0]    link_value;
        logic [DATA_W-1:0]    branch_target;
        logic                 take_branch;
        logic                 mode_update;
        logic                 bad_mode;
        logic [DATA_W-1:0]    cpsr_value;
    } result_t;

    function automatic logic [BANK_W-1:0] bank_of_mode(input logic [MODE_W-1:0] mode);
        logic [BANK_W-1:0] bank;
        case (mode)
            MODE_FIQ: bank = BANK_FIQ;
            MODE_IRQ: bank = BANK_IRQ;
            MODE_SVC: bank = BANK_SVC;
            MODE_ABT: bank = BANK_ABT;
            MODE_UND: bank = BANK_UND;
            default:  bank = BANK_NONE;
        endcase
        return bank;
    endfunction

endpackage

`default_nettype wire

@@ rtl/psrt_front.sv @@
`default_nettype none

module psrt_front (
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [2:0]                   req_type,
    input  wire logic [31:0]                  instr_word,
    input  wire logic [31:0]                  operand_value,
    input  wire logic                         high_vectors,
    input  wire logic                         q_full,
    output logic                              push,
    output psrt_pkg::decoded_t                push_data
);
    import psrt_pkg::*;

    logic [2*DATA_W-1:0] rot_pair;
    logic [4:0]          rot_amt;
    logic [DATA_W-1:0]   imm_value;
    logic [DATA_W-1:0]   base;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        rot_amt   = instr_word[11:7] & ROT_MASK;
        rot_pair  = {24'd0, instr_word[7:0], 24'd0, instr_word[7:0]} >> rot_amt;
        imm_value = rot_pair[DATA_W-1:0];
        base      = high_vectors ? HIGH_BASE : '0;

        push_data.use_spsr  = instr_word[22];
        push_data.lane_mask = {{8{instr_word[19]}}, {8{instr_word[18]}},
                               {8{instr_word[17]}}, {8{instr_word[16]}}};
        if (!instr_word[22])
        begin
            push_data.lane_mask = push_data.lane_mask & MASK_T;
        end
        push_data.dest_reg      = instr_word[15:12];
        push_data.branch_target = base + VEC_SVC;
        push_data.value         = operand_value;
        push_data.link_value    = operand_value - LINK_ARM;
        push_data.op            = OP_NONE;

        case (req_type)
            REQ_MSR_IMM:
            begin
                push_data.op    = OP_MSR;
                push_data.value = imm_value;
            end
            REQ_MSR_REG:
            begin
                push_data.op = OP_MSR;
            end
            REQ_MRS:
            begin
                push_data.op = OP_MRS;
            end
            REQ_SVC_ARM:
            begin
                push_data.op = OP_SVC;
            end
            REQ_SVC_THUMB:
            begin
                push_data.op         = OP_SVC;
                push_data.link_value = operand_value - LINK_THUMB;
            end
            default:
            begin
                push_data.op = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/psrt_queue.sv @@
`default_nettype none

module psrt_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire psrt_pkg::decoded_t   push_data,
    output logic                      full,
    output logic                      q_valid,
    output psrt_pkg::decoded_t        q_data,
    input  wire logic                 pop
);
    import psrt_pkg::*;

    decoded_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ rtl/psrt_back.sv @@
`default_nettype none

module psrt_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire psrt_pkg::decoded_t   q_data,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output psrt_pkg::result_t         res
);
    import psrt_pkg::*;

    logic [DATA_W-1:0] cpsr_reg;
    logic [DATA_W-1:0] cpsr_next;
    logic [DATA_W-1:0] spsr_reg [BANK_N];
    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res_next;

    logic [BANK_W-1:0] bank;
    logic              has_bank;
    logic              user_mode;
    logic [DATA_W-1:0] spsr_cur;
    logic [DATA_W-1:0] mask;
    logic              spsr_wr_en;
    logic [BANK_W-1:0] spsr_wr_idx;
    logic [DATA_W-1:0] spsr_wr_data;

    assign pop       = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        bank      = bank_of_mode(cpsr_reg[MODE_W-1:0]);
        has_bank  = (bank != BANK_NONE);
        user_mode = (cpsr_reg[MODE_W-1:0] == MODE_USR);

        spsr_cur = '0;
        for (int i = 0; i < BANK_N; i++)
        begin
            if (bank == BANK_W'(i))
            begin
                spsr_cur = spsr_reg[i];
            end
        end

        mask = q_data.lane_mask;
        if (user_mode)
        begin
            mask = mask & MASK_USR;
        end

        cpsr_next    = cpsr_reg;
        spsr_wr_en   = 1'b0;
        spsr_wr_idx  = bank;
        spsr_wr_data = (spsr_cur & ~mask) | (q_data.value & mask);
        res_next     = '0;

        case (q_data.op)
            OP_MSR:
            begin
                if (q_data.use_spsr && !has_bank)
                begin
                    res_next.bad_mode = 1'b1;
                end
                else if (q_data.use_spsr)
                begin
                    spsr_wr_en = 1'b1;
                end
                else
                begin
                    cpsr_next            = (cpsr_reg & ~mask) | (q_data.value & mask);
                    res_next.mode_update = 1'b1;
                end
            end
            OP_MRS:
            begin
                if (q_data.use_spsr && !has_bank)
                begin
                    res_next.bad_mode = 1'b1;
                end
                else
                begin
                    res_next.psr_value  = q_data.use_spsr ? spsr_cur : cpsr_reg;
                    res_next.dest_reg   = q_data.dest_reg;
                    res_next.write_dest = 1'b1;
                end
            end
            OP_SVC:
            begin
                cpsr_next              = {cpsr_reg[DATA_W-1:8], SVC_LOW_BYTE};
                spsr_wr_en             = 1'b1;
                spsr_wr_idx            = BANK_SVC;
                spsr_wr_data           = cpsr_reg;
                res_next.link_value    = q_data.link_value;
                res_next.branch_target = q_data.branch_target;
                res_next.take_branch   = 1'b1;
                res_next.mode_update   = 1'b1;
            end
            default:
            begin
                cpsr_next = cpsr_reg;
            end
        endcase

        res_next.cpsr_value = cpsr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpsr_reg      <= CPSR_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BANK_N; i++)
            begin
                spsr_reg[i] <= '0;
            end
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                cpsr_reg      <= cpsr_next;
                for (int i = 0; i < BANK_N; i++)
                begin
                    if (spsr_wr_en && (spsr_wr_idx == BANK_W'(i)))
                    begin
                        spsr_reg[i] <= spsr_wr_data;
                    end
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    a_svc_low_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.take_branch |-> res_reg.cpsr_value[7:0] == SVC_LOW_BYTE)
        else $error("svc result without supervisor low byte");

    a_bad_mode_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.bad_mode |->
            !res_reg.write_dest && !res_reg.mode_update && !res_reg.take_branch)
        else $error("bad_mode item with side effects");

    a_t_bit_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (q_data.op == OP_MSR) && !q_data.use_spsr |=>
            cpsr_reg[5] == $past(cpsr_reg[5]))
        else $error("msr changed the T bit");

    a_cpsr_reported: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && (res_reg.cpsr_value == cpsr_reg))
        else $error("reported cpsr differs from state");

endmodule

`default_nettype wire

@@ rtl/psr_transfer_unit_top.sv @@
// Status-register unit: holds the CPSR and the FIQ/IRQ/SVC/ABT/UND SPSRs and
// executes one MSR, MRS or SVC per item, giving one result item for each.
// Sustained rate is one item per clock while out_stall is low; an accepted item
// is decoded into a two-entry queue, then executed against the status registers
// into the output register. The execute stage holds the loop from CPSR back
// to CPSR, which MSR and SVC items update. With the output stalled,
// up to three items are held before in_stall rises. high_vectors sits at byte
// address 0 of the APB port and must be written only while the block is idle.
`default_nettype none

module psr_transfer_unit_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [psrt_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    req_type,
    input  wire logic [31:0]                   instr_word,
    input  wire logic [31:0]                   operand_value,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [31:0]                        psr_value,
    output logic [3:0]                         dest_reg,
    output logic                               write_dest,
    output logic [31:0]                        link_value,
    output logic [31:0]                        branch_target,
    output logic                               take_branch,
    output logic                               mode_update,
    output logic                               bad_mode,
    output logic [31:0]                        cpsr_value
);
    import psrt_pkg::*;

    logic       high_vectors_reg;
    logic       high_vectors_next;
    logic       reg_sel;
    logic       q_full;
    logic       push;
    decoded_t   push_data;
    logic       q_valid;
    decoded_t   q_data;
    logic       pop;
    result_t    res;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1:2] == ADDR_HIGH_VECTORS[ADDR_W-1:2]);
    assign prdata  = reg_sel ? {31'd0, high_vectors_reg} : 32'd0;

    always_comb
    begin
        high_vectors_next = high_vectors_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            high_vectors_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_vectors_reg <= 1'b0;
        end
        else
        begin
            high_vectors_reg <= high_vectors_next;
        end
    end

    psrt_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .instr_word    (instr_word),
        .operand_value (operand_value),
        .high_vectors  (high_vectors_reg),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    psrt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    psrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign psr_value     = res.psr_value;
    assign dest_reg      = res.dest_reg;
    assign write_dest    = res.write_dest;
    assign link_value    = res.link_value;
    assign branch_target = res.branch_target;
    assign take_branch   = res.take_branch;
    assign mode_update   = res.mode_update;
    assign bad_mode      = res.bad_mode;
    assign cpsr_value    = res.cpsr_value;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
module testbench;
    import psrt_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        in_valid = 1'b0;
    wire         in_stall;
    logic [2:0]  req_type = '0;
    logic [31:0] instr_word = '0;
    logic [31:0] operand_value = '0;
    wire         out_valid;
    logic        out_stall = 1'b0;
    wire  [31:0] psr_value;
    wire  [3:0]  dest_reg;
    wire         write_dest;
    wire  [31:0] link_value;
    wire  [31:0] branch_target;
    wire         take_branch;
    wire         mode_update;
    wire         bad_mode;
    wire  [31:0] cpsr_value;

    logic [31:0] cpsr_model = CPSR_RESET;
    logic [31:0] spsr_model [BANK_N] = '{default: '0};
    logic        hi_vec_model = 1'b0;
    result_t     expected_results [$];
    result_t     head;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int cycle_count = 0;

    psr_transfer_unit_top DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .instr_word(instr_word), .operand_value(operand_value),
        .out_valid(out_valid), .out_stall(out_stall), .psr_value(psr_value),
        .dest_reg(dest_reg), .write_dest(write_dest), .link_value(link_value),
        .branch_target(branch_target), .take_branch(take_branch),
        .mode_update(mode_update), .bad_mode(bad_mode), .cpsr_value(cpsr_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results pending", $time, expected_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [BANK_W-1:0] spsr_slot(input logic [MODE_W-1:0] mode);
        logic [BANK_W-1:0] slot;
        slot = BANK_NONE;
        if (mode == MODE_FIQ) slot = BANK_FIQ;
        if (mode == MODE_IRQ) slot = BANK_IRQ;
        if (mode == MODE_SVC) slot = BANK_SVC;
        if (mode == MODE_ABT) slot = BANK_ABT;
        if (mode == MODE_UND) slot = BANK_UND;
        return slot;
    endfunction

    function automatic result_t predict_status(input logic [2:0] rq, input logic [31:0] iw,
                                               input logic [31:0] ov);
        result_t r;
        logic spsr_sel;
        logic [BANK_W-1:0] slot;
        logic [31:0] mask;
        logic [31:0] val;
        logic [63:0] twice;
        r = '0;
        spsr_sel = iw[22];
        slot = spsr_slot(cpsr_model[MODE_W-1:0]);
        if (rq <= REQ_MRS && spsr_sel && slot == BANK_NONE)
            r.bad_mode = 1'b1;
        else if (rq == REQ_MSR_IMM || rq == REQ_MSR_REG)
        begin
            mask = {{8{iw[19]}}, {8{iw[18]}}, {8{iw[17]}}, {8{iw[16]}}};
            twice = {24'h0, iw[7:0], 24'h0, iw[7:0]};
            twice = twice >> {iw[11:8], 1'b0};
            val = (rq == REQ_MSR_IMM) ? twice[31:0] : ov;
            if (!spsr_sel)
                mask = mask & MASK_T;
            if (cpsr_model[MODE_W-1:0] == MODE_USR)
                mask = mask & MASK_USR;
            if (spsr_sel)
                spsr_model[slot] = (spsr_model[slot] & ~mask) | (val & mask);
            else
            begin
                cpsr_model = (cpsr_model & ~mask) | (val & mask);
                r.mode_update = 1'b1;
            end
        end
        else if (rq == REQ_MRS)
        begin
            r.psr_value = spsr_sel ? spsr_model[slot] : cpsr_model;
            r.dest_reg = iw[15:12];
            r.write_dest = 1'b1;
        end
        else if (rq == REQ_SVC_ARM || rq == REQ_SVC_THUMB)
        begin
            spsr_model[BANK_SVC] = cpsr_model;
            cpsr_model = {cpsr_model[31:8], SVC_LOW_BYTE};
            r.link_value = ov - ((rq == REQ_SVC_ARM) ? LINK_ARM : LINK_THUMB);
            r.branch_target = (hi_vec_model ? HIGH_BASE : 32'h0) + VEC_SVC;
            r.take_branch = 1'b1;
            r.mode_update = 1'b1;
        end
        r.cpsr_value = cpsr_model;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item pending, expected none actual cpsr %h",
                         $time, cpsr_value);
            end
            else
            begin
                head = expected_results.pop_front();
                compare_field("psr_value", head.psr_value, psr_value);
                compare_field("dest_reg", 32'(head.dest_reg), 32'(dest_reg));
                compare_field("write_dest", 32'(head.write_dest), 32'(write_dest));
                compare_field("link_value", head.link_value, link_value);
                compare_field("branch_target", head.branch_target, branch_target);
                compare_field("take_branch", 32'(head.take_branch), 32'(take_branch));
                compare_field("mode_update", 32'(head.mode_update), 32'(mode_update));
                compare_field("bad_mode", 32'(head.bad_mode), 32'(bad_mode));
                compare_field("cpsr_value", head.cpsr_value, cpsr_value);
                results_seen++;
            end
        end
    end

    function automatic logic [31:0] encode(input logic spsr, input logic [3:0] lanes,
                                           input logic [3:0] rd, input logic [3:0] rot,
                                           input logic [7:0] imm);
        return {9'h0, spsr, 2'b00, lanes, rd, rot, imm};
    endfunction

    task automatic send_item(input logic [2:0] rq, input logic [31:0] iw, input logic [31:0] ov);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        instr_word <= iw;
        operand_value <= ov;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_status(rq, iw, ov));
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_high_vectors(input logic v);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_HIGH_VECTORS;
        pwdata <= ($urandom & 32'hFFFF_FFFE) | {31'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        hi_vec_model = v;
    endtask

    function automatic logic [MODE_W-1:0] pick_mode();
        case ($urandom_range(7, 0))
            0: return MODE_USR;
            1: return MODE_FIQ;
            2: return MODE_IRQ;
            3: return MODE_SVC;
            4: return MODE_ABT;
            5: return MODE_UND;
            6: return MODE_SYS;
            default: return MODE_W'($urandom);
        endcase
    endfunction

    task automatic send_random_item();
        logic [2:0] rq;
        logic [31:0] iw;
        logic [31:0] ov;
        logic [MODE_W-1:0] mode;
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 30)
            rq = REQ_MSR_IMM;
        else if (pick < 55)
            rq = REQ_MSR_REG;
        else if (pick < 80)
            rq = REQ_MRS;
        else if (pick < 88)
            rq = REQ_SVC_ARM;
        else if (pick < 96)
            rq = REQ_SVC_THUMB;
        else
            rq = 3'(REQ_SVC_THUMB + 1 + $urandom_range(2, 0));
        iw = $urandom;
        case ($urandom_range(9, 0))
            0: ov = 32'h0;
            1: ov = 32'hFFFF_FFFF;
            default: ov = $urandom;
        endcase
        if ((rq == REQ_MSR_IMM || rq == REQ_MSR_REG) && !iw[22] && iw[16]
            && $urandom_range(9, 0) < 7)
        begin
            mode = pick_mode();
            if (rq == REQ_MSR_REG)
                ov[MODE_W-1:0] = mode;
            else
            begin
                iw[11:8] = 4'h0;
                iw[MODE_W-1:0] = mode;
            end
        end
        send_item(rq, iw, ov);
    endtask

    task automatic test_reset_state();
        send_item(REQ_MRS, encode(1'b0, 4'h0, 4'hF, 4'h0, 8'h00), 32'h0);
        send_item(REQ_MRS, encode(1'b1, 4'h0, 4'h0, 4'h0, 8'h00), 32'h0);
    endtask

    task automatic test_msr_cpsr();
        send_item(REQ_MSR_IMM, encode(1'b0, 4'h8, 4'h0, 4'h4, 8'hF0), $urandom);
        send_item(REQ_MSR_IMM, encode(1'b0, 4'h0, 4'h0, 4'hF, 8'hFF), $urandom);
        send_item(REQ_MSR_REG, encode(1'b0, 4'hF, 4'h0, 4'h0, 8'h00), 32'hFFFF_FFFF);
        send_item(REQ_MRS, encode(1'b1, 4'h0, 4'h7, 4'h0, 8'h00), 32'h0);
        send_item(REQ_MSR_REG, encode(1'b1, 4'hF, 4'h0, 4'h0, 8'h00), 32'hFFFF_FFFF);
        send_item(REQ_MSR_REG, encode(1'b0, 4'hF, 4'h0, 4'h0, 8'h00), {27'h6, MODE_SVC});
    endtask

    task automatic test_spsr_banks();
        logic [MODE_W-1:0] modes [5];
        modes = '{MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND};
        foreach (modes[i])
        begin
            send_item(REQ_MSR_REG, encode(1'b0, 4'h1, 4'h0, 4'h0, 8'h00), {27'h6, modes[i]});
            send_item(REQ_MSR_IMM, encode(1'b1, 4'hF, 4'h0, 4'($urandom), 8'($urandom)),
                      $urandom);
        end
        send_item(REQ_MRS, encode(1'b1, 4'h0, 4'h3, 4'h0, 8'h00), 32'h0);
    endtask

    task automatic test_user_mode();
        send_item(REQ_MSR_REG, encode(1'b0, 4'h1, 4'h0, 4'h0, 8'h00), {27'h6, MODE_USR});
        send_item(REQ_MSR_REG, encode(1'b0, 4'hF, 4'h0, 4'h0, 8'h00), 32'h0);
    endtask

    task automatic test_svc();
        send_item(REQ_SVC_ARM, $urandom, 32'h0);
        write_high_vectors(1'b1);
        send_item(REQ_SVC_THUMB, $urandom, 32'h1);
        write_high_vectors(1'b0);
    endtask

    task automatic test_unused_requests();
        for (int r = REQ_SVC_THUMB + 1; r < 8; r++)
            send_item(3'(r), $urandom, $urandom);
    endtask

    task automatic test_random(input int sender_pct, input int receiver_pct, input int count);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (count) send_random_item();
    endtask

    task automatic test_backpressure();
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left <= HOLD_CYCLES;
        repeat (40) send_random_item();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 27;
        recv_idle_pct = 79;
        write_high_vectors(1'b0);
        test_reset_state();
        test_msr_cpsr();
        test_spsr_banks();
        test_user_mode();
        test_svc();
        test_unused_requests();
        write_high_vectors(1'b1);
        test_random(27, 79, RANDOM_ITEMS / 3);
        write_high_vectors(1'b0);
        test_random(79, 27, RANDOM_ITEMS / 3);
        write_high_vectors(1'b1);
        test_random(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        test_backpressure();
        wait_drained();
        $display("Ran %0d items and checked %0d results: MSR/MRS on every bank, SVC on both",
                 items_sent, results_seen);
        $display("vector bases, unused requests, three stall mixes and a long output hold-off");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
